/* rtl/message_interval_jitter_monitor_core_assert.svh */
// Assertion macros for the message interval jitter monitor.
// Used by the top level; expects signals clk and rst_n in scope.
`ifndef MESSAGE_INTERVAL_JITTER_MONITOR_CORE_ASSERT_SVH
`define MESSAGE_INTERVAL_JITTER_MONITOR_CORE_ASSERT_SVH

// Condition in this cycle implies consequence in the same cycle.
`define MIJM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Condition in this cycle implies consequence in the next cycle.
`define MIJM_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* rtl/mijm_pkg.sv */
// Shared types and constants for the message interval jitter monitor.
// No dependencies; imported by the controller, the datapath and the top level.
package mijm_pkg;

    localparam int COUNT_BITS = 20;
    localparam int TIME_BITS  = 32;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [63:0] Q40_MAX = 64'h0000_00FF_FFFF_FFFF;
    localparam logic [63:0] Q24_MAX = 64'h0000_0000_00FF_FFFF;

    // Jitter thresholds in Q.8 percent.
    localparam logic [23:0] JIT_5PCT  = 24'd1280;
    localparam logic [23:0] JIT_10PCT = 24'd2560;
    localparam logic [23:0] JIT_20PCT = 24'd5120;
    localparam logic [23:0] JIT_50PCT = 24'd12800;

    // 100 squared, the percent scale applied under the square root.
    localparam logic [31:0] PCT_SQ_SCALE = 32'd10000;

    localparam logic [1:0] REG_TERMINAL = 2'd0;
    localparam logic [1:0] REG_SUBADDR  = 2'd1;
    localparam logic [1:0] REG_WIN_LO   = 2'd2;
    localparam logic [1:0] REG_WIN_HI   = 2'd3;

    localparam logic [1:0] STATUS_VALID  = 2'd0;
    localparam logic [1:0] STATUS_EMPTY  = 2'd1;
    localparam logic [1:0] STATUS_SINGLE = 2'd2;

    localparam logic [2:0] CLASS_BELOW_5  = 3'd0;
    localparam logic [2:0] CLASS_BELOW_10 = 3'd1;
    localparam logic [2:0] CLASS_BELOW_20 = 3'd2;
    localparam logic [2:0] CLASS_BELOW_50 = 3'd3;
    localparam logic [2:0] CLASS_ABOVE    = 3'd4;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_REC,
        OP_SQ_GAP,
        OP_ACC_SQ,
        OP_NQ_LO,
        OP_NQ_HI,
        OP_SS,
        OP_VSUB,
        OP_SQRT_DEV,
        OP_DIV_DEV,
        OP_DIV_MEAN,
        OP_MV0,
        OP_MV1,
        OP_MV2,
        OP_MV3,
        OP_SQRT_JIT,
        OP_DIV_JIT,
        OP_LOAD
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic fewer_than_two;
        logic sum_zero;
        logic sqrt_done;
        logic div_done;
        logic out_free;
    } dp_stat_t;

endpackage

/* rtl/mijm_sqrt.sv */
// Bit-serial integer square root, two radicand bits per cycle.
// Depends on nothing beyond its ports.
module mijm_sqrt (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [115:0] radicand,
    output logic         done,
    output logic [57:0]  root
);
    logic [115:0] x_reg;
    logic [61:0]  rem_reg;
    logic [57:0]  root_reg;
    logic [5:0]   cnt_reg;
    logic         run_reg;
    logic         done_reg;
    logic [61:0]  rem_sh;
    logic [61:0]  trial;
    logic         fits;

    assign rem_sh = {rem_reg[59:0], x_reg[115:114]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign fits   = (rem_sh >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= 6'd57;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (run_reg)
        begin
            x_reg    <= {x_reg[113:0], 2'b00};
            rem_reg  <= fits ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[56:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule

/* rtl/mijm_div.sv */
// Restoring radix-2 divider, 64-bit dividend by 32-bit divisor.
// Depends on nothing beyond its ports.
module mijm_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);
    logic [63:0] q_reg;
    logic [31:0] rem_reg;
    logic [31:0] dvs_reg;
    logic [5:0]  cnt_reg;
    logic        run_reg;
    logic        done_reg;
    logic [32:0] rem_sh;
    logic        fits;

    assign rem_sh = {rem_reg, q_reg[63]};
    assign fits   = (rem_sh >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= 6'd63;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (run_reg)
        begin
            rem_reg <= fits ? 32'(rem_sh - {1'b0, dvs_reg}) : rem_sh[31:0];
            q_reg   <= {q_reg[62:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;
endmodule

/* rtl/mijm_datapath.sv */
// Datapath: configuration, record filter, accumulators, shared multiplier,
// report arithmetic and output register. Uses mijm_pkg, mijm_sqrt, mijm_div.
module mijm_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic [4:0]          record_terminal,
    input  logic [4:0]          record_subaddress,
    input  logic [31:0]         timestamp_ms,
    input  mijm_pkg::dp_cmd_t   cmd,
    output mijm_pkg::dp_stat_t  stat,
    input  logic                out_stall,
    output logic                out_valid,
    output logic [1:0]          status,
    output logic [19:0]         record_count,
    output logic [31:0]         min_interval_ms,
    output logic [31:0]         max_interval_ms,
    output logic [39:0]         mean_interval_q8,
    output logic [39:0]         deviation_q8,
    output logic [23:0]         jitter_percent_q8,
    output logic [2:0]          stability_class,
    output logic                is_stable,
    output logic                order_error
);
    import mijm_pkg::*;

    typedef enum logic [1:0] {
        DEST_DEV,
        DEST_MEAN,
        DEST_JIT
    } div_dest_t;

    logic [4:0]            terminal_reg;
    logic [4:0]            subaddr_reg;
    logic [TIME_BITS-1:0]  win_lo_reg;
    logic [TIME_BITS-1:0]  win_hi_reg;

    logic [COUNT_BITS-1:0] count_reg;
    logic [TIME_BITS-1:0]  prev_reg;
    logic [TIME_BITS-1:0]  min_reg;
    logic [TIME_BITS-1:0]  max_reg;
    logic [TIME_BITS-1:0]  sum_reg;
    logic [63:0]           sqsum_reg;
    logic                  fault_reg;

    logic [TIME_BITS-1:0]  gap_reg;
    logic [63:0]           mul_reg;
    logic [97:0]           acc_reg;
    logic [83:0]           v_reg;
    logic [39:0]           dev_reg;
    logic [39:0]           mean_reg;
    logic [23:0]           jit_reg;
    div_dest_t             dest_reg;
    logic                  out_valid_reg;

    logic                  keep;
    logic                  early;
    logic [TIME_BITS-1:0]  gap;
    logic [TIME_BITS:0]    sum_wide;
    logic [64:0]           sqsum_wide;
    logic [COUNT_BITS-1:0] n_val;
    logic [31:0]           mul_a;
    logic [31:0]           mul_b;
    logic                  sqrt_start;
    logic [115:0]          radicand;
    logic                  sqrt_done;
    logic [57:0]           root;
    logic                  div_start;
    logic [63:0]           dividend;
    logic [31:0]           divisor;
    logic                  div_done;
    logic [63:0]           quotient;
    logic                  few;
    logic                  sum_zero;
    logic [23:0]           jit_eff;

    assign keep = (record_terminal == terminal_reg) && (record_subaddress == subaddr_reg)
                  && !((win_lo_reg != '0) && (timestamp_ms < win_lo_reg))
                  && !((win_hi_reg != '0) && (timestamp_ms > win_hi_reg));
    assign early      = (timestamp_ms < prev_reg);
    assign gap        = early ? '0 : (timestamp_ms - prev_reg);
    assign sum_wide   = {1'b0, sum_reg} + {1'b0, gap_reg};
    assign sqsum_wide = {1'b0, sqsum_reg} + {1'b0, mul_reg};
    assign n_val      = count_reg - COUNT_BITS'(1);
    assign few        = (count_reg < COUNT_BITS'(2));
    assign sum_zero   = (sum_reg == '0);
    assign jit_eff    = sum_zero ? '0 : jit_reg;

    // Operand selection for the shared 32 x 32 multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_SQ_GAP:
            begin
                mul_a = gap_reg;
                mul_b = gap_reg;
            end
            OP_NQ_LO:
            begin
                mul_a = {12'b0, n_val};
                mul_b = sqsum_reg[31:0];
            end
            OP_NQ_HI:
            begin
                mul_a = {12'b0, n_val};
                mul_b = sqsum_reg[63:32];
            end
            OP_SS:
            begin
                mul_a = sum_reg;
                mul_b = sum_reg;
            end
            OP_MV0:
            begin
                mul_a = v_reg[31:0];
                mul_b = PCT_SQ_SCALE;
            end
            OP_MV1:
            begin
                mul_a = v_reg[63:32];
                mul_b = PCT_SQ_SCALE;
            end
            OP_MV2:
            begin
                mul_a = {12'b0, v_reg[83:64]};
                mul_b = PCT_SQ_SCALE;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign sqrt_start = (cmd.op == OP_SQRT_DEV) || (cmd.op == OP_SQRT_JIT);
    assign radicand   = (cmd.op == OP_SQRT_DEV) ? {16'b0, v_reg, 16'b0}
                                                : {2'b0, acc_reg, 16'b0};
    assign div_start  = (cmd.op == OP_DIV_DEV) || (cmd.op == OP_DIV_MEAN)
                        || (cmd.op == OP_DIV_JIT);

    always_comb
    begin
        dividend = {6'b0, root};
        divisor  = {12'b0, n_val};
        case (cmd.op)
            OP_DIV_MEAN:
            begin
                dividend = {24'b0, sum_reg, 8'b0};
                divisor  = {12'b0, n_val};
            end
            OP_DIV_JIT:
            begin
                dividend = {6'b0, root};
                divisor  = sum_reg;
            end
            default:
            begin
                dividend = {6'b0, root};
                divisor  = {12'b0, n_val};
            end
        endcase
    end

    mijm_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (radicand),
        .done     (sqrt_done),
        .root     (root)
    );

    mijm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    // Configuration, per-set accumulators and the output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            terminal_reg  <= '0;
            subaddr_reg   <= '0;
            win_lo_reg    <= '0;
            win_hi_reg    <= '0;
            count_reg     <= '0;
            prev_reg      <= '0;
            min_reg       <= '1;
            max_reg       <= '0;
            sum_reg       <= '0;
            sqsum_reg     <= '0;
            fault_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_TERMINAL: terminal_reg <= cfg_data[4:0];
                    REG_SUBADDR:  subaddr_reg  <= cfg_data[4:0];
                    REG_WIN_LO:   win_lo_reg   <= cfg_data[TIME_BITS-1:0];
                    REG_WIN_HI:   win_hi_reg   <= cfg_data[TIME_BITS-1:0];
                    default:      ;
                endcase
            end

            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (cmd.op)
                OP_REC:
                begin
                    if (keep)
                    begin
                        prev_reg <= timestamp_ms;
                        if (count_reg == '0)
                        begin
                            count_reg <= COUNT_BITS'(1);
                        end
                        else
                        begin
                            if (early)
                            begin
                                fault_reg <= 1'b1;
                            end
                            if (count_reg != COUNT_MAX)
                            begin
                                count_reg <= count_reg + COUNT_BITS'(1);
                            end
                            if (gap < min_reg)
                            begin
                                min_reg <= gap;
                            end
                            if (gap > max_reg)
                            begin
                                max_reg <= gap;
                            end
                        end
                    end
                end
                OP_ACC_SQ:
                begin
                    // The gap itself joins the sum here, alongside its square.
                    sum_reg   <= sum_wide[TIME_BITS] ? '1 : sum_wide[TIME_BITS-1:0];
                    sqsum_reg <= sqsum_wide[64] ? '1 : sqsum_wide[63:0];
                end
                OP_LOAD:
                begin
                    out_valid_reg <= 1'b1;
                    count_reg     <= '0;
                    prev_reg      <= '0;
                    min_reg       <= '1;
                    max_reg       <= '0;
                    sum_reg       <= '0;
                    sqsum_reg     <= '0;
                    fault_reg     <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // Working registers of the report arithmetic.
    always_ff @(posedge clk)
    begin
        mul_reg <= mul_a * mul_b;

        case (cmd.op)
            OP_REC:
            begin
                gap_reg <= (keep && (count_reg != '0)) ? gap : '0;
            end
            OP_NQ_LO, OP_MV0:
            begin
                acc_reg <= '0;
            end
            OP_NQ_HI, OP_MV1:
            begin
                acc_reg <= acc_reg + {34'b0, mul_reg};
            end
            OP_SS, OP_MV2:
            begin
                acc_reg <= acc_reg + {2'b0, mul_reg, 32'b0};
            end
            OP_MV3:
            begin
                acc_reg <= acc_reg + {mul_reg[33:0], 64'b0};
            end
            OP_VSUB:
            begin
                v_reg <= (acc_reg[83:0] >= {20'b0, mul_reg})
                         ? (acc_reg[83:0] - {20'b0, mul_reg}) : '0;
            end
            OP_DIV_DEV:  dest_reg <= DEST_DEV;
            OP_DIV_MEAN: dest_reg <= DEST_MEAN;
            OP_DIV_JIT:  dest_reg <= DEST_JIT;
            default: ;
        endcase

        if (div_done)
        begin
            case (dest_reg)
                DEST_DEV:  dev_reg  <= (quotient > Q40_MAX) ? '1 : quotient[39:0];
                DEST_MEAN: mean_reg <= (quotient > Q40_MAX) ? '1 : quotient[39:0];
                DEST_JIT:  jit_reg  <= (quotient > Q24_MAX) ? '1 : quotient[23:0];
                default: ;
            endcase
        end

        if (cmd.op == OP_LOAD)
        begin
            record_count <= count_reg;
            order_error  <= fault_reg;
            if (few)
            begin
                status            <= (count_reg == '0) ? STATUS_EMPTY : STATUS_SINGLE;
                min_interval_ms   <= '0;
                max_interval_ms   <= '0;
                mean_interval_q8  <= '0;
                deviation_q8      <= '0;
                jitter_percent_q8 <= '0;
                stability_class   <= CLASS_BELOW_5;
                is_stable         <= 1'b0;
            end
            else
            begin
                status            <= STATUS_VALID;
                min_interval_ms   <= min_reg;
                max_interval_ms   <= max_reg;
                mean_interval_q8  <= mean_reg;
                deviation_q8      <= dev_reg;
                jitter_percent_q8 <= jit_eff;
                is_stable         <= (jit_eff < JIT_10PCT);
                if (jit_eff < JIT_5PCT)
                begin
                    stability_class <= CLASS_BELOW_5;
                end
                else if (jit_eff < JIT_10PCT)
                begin
                    stability_class <= CLASS_BELOW_10;
                end
                else if (jit_eff < JIT_20PCT)
                begin
                    stability_class <= CLASS_BELOW_20;
                end
                else if (jit_eff < JIT_50PCT)
                begin
                    stability_class <= CLASS_BELOW_50;
                end
                else
                begin
                    stability_class <= CLASS_ABOVE;
                end
            end
        end
    end

    assign stat.fewer_than_two = few;
    assign stat.sum_zero       = sum_zero;
    assign stat.sqrt_done      = sqrt_done;
    assign stat.div_done       = div_done;
    assign stat.out_free       = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
endmodule

/* rtl/mijm_ctrl.sv */
// Controller state machine sequencing record updates and the report.
// Uses mijm_pkg; drives the datapath through dp_cmd_t.
module mijm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                command,
    output logic                in_stall,
    output mijm_pkg::dp_cmd_t   cmd,
    input  mijm_pkg::dp_stat_t  stat
);
    import mijm_pkg::*;

    typedef enum logic [21:0] {
        ST_IDLE     = 22'h000001,
        ST_REC_SQ   = 22'h000002,
        ST_REC_ACC  = 22'h000004,
        ST_NQ_LO    = 22'h000008,
        ST_NQ_HI    = 22'h000010,
        ST_SS       = 22'h000020,
        ST_VSUB     = 22'h000040,
        ST_SQD_GO   = 22'h000080,
        ST_SQD_WAIT = 22'h000100,
        ST_DVD_GO   = 22'h000200,
        ST_DVD_WAIT = 22'h000400,
        ST_DVM_GO   = 22'h000800,
        ST_DVM_WAIT = 22'h001000,
        ST_MV0      = 22'h002000,
        ST_MV1      = 22'h004000,
        ST_MV2      = 22'h008000,
        ST_MV3      = 22'h010000,
        ST_SQJ_GO   = 22'h020000,
        ST_SQJ_WAIT = 22'h040000,
        ST_DVJ_GO   = 22'h080000,
        ST_DVJ_WAIT = 22'h100000,
        ST_FINISH   = 22'h200000
    } ctrl_state_t;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        accept;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (command)
                    begin
                        state_next = stat.fewer_than_two ? ST_FINISH : ST_NQ_LO;
                    end
                    else
                    begin
                        cmd.op     = OP_REC;
                        state_next = ST_REC_SQ;
                    end
                end
            end
            ST_REC_SQ:
            begin
                cmd.op     = OP_SQ_GAP;
                state_next = ST_REC_ACC;
            end
            ST_REC_ACC:
            begin
                cmd.op     = OP_ACC_SQ;
                state_next = ST_IDLE;
            end
            ST_NQ_LO:
            begin
                cmd.op     = OP_NQ_LO;
                state_next = ST_NQ_HI;
            end
            ST_NQ_HI:
            begin
                cmd.op     = OP_NQ_HI;
                state_next = ST_SS;
            end
            ST_SS:
            begin
                cmd.op     = OP_SS;
                state_next = ST_VSUB;
            end
            ST_VSUB:
            begin
                cmd.op     = OP_VSUB;
                state_next = ST_SQD_GO;
            end
            ST_SQD_GO:
            begin
                cmd.op     = OP_SQRT_DEV;
                state_next = ST_SQD_WAIT;
            end
            ST_SQD_WAIT:
            begin
                if (stat.sqrt_done)
                begin
                    state_next = ST_DVD_GO;
                end
            end
            ST_DVD_GO:
            begin
                cmd.op     = OP_DIV_DEV;
                state_next = ST_DVD_WAIT;
            end
            ST_DVD_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_DVM_GO;
                end
            end
            ST_DVM_GO:
            begin
                cmd.op     = OP_DIV_MEAN;
                state_next = ST_DVM_WAIT;
            end
            ST_DVM_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_MV0;
                end
            end
            ST_MV0:
            begin
                cmd.op     = OP_MV0;
                state_next = ST_MV1;
            end
            ST_MV1:
            begin
                cmd.op     = OP_MV1;
                state_next = ST_MV2;
            end
            ST_MV2:
            begin
                cmd.op     = OP_MV2;
                state_next = ST_MV3;
            end
            ST_MV3:
            begin
                cmd.op     = OP_MV3;
                state_next = ST_SQJ_GO;
            end
            ST_SQJ_GO:
            begin
                cmd.op     = OP_SQRT_JIT;
                state_next = ST_SQJ_WAIT;
            end
            ST_SQJ_WAIT:
            begin
                if (stat.sqrt_done)
                begin
                    state_next = stat.sum_zero ? ST_FINISH : ST_DVJ_GO;
                end
            end
            ST_DVJ_GO:
            begin
                cmd.op     = OP_DIV_JIT;
                state_next = ST_DVJ_WAIT;
            end
            ST_DVJ_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

/* rtl/message_interval_jitter_monitor_core.sv */
// Top level of the message interval jitter monitor.
// Uses mijm_pkg, mijm_ctrl, mijm_datapath and the assertion macro header.
//
// The block watches bus-monitor records, keeps those whose terminal address
// and subaddress match the configured pair and whose timestamp lies inside
// the optional window, and accumulates the gaps between kept records. A
// record item (command 0) is accepted and filtered, then its gap is squared
// on the shared 32 x 32 multiplier, and then the square is added to the
// sum of squares; in_stall is high while the square is formed and added.
// An end-of-set item (command 1) produces exactly one result item and
// clears the statistics, keeping the configuration. With fewer than two
// kept records the controller goes straight to loading the result.
// Otherwise the report runs through the serial units: a 58-step square
// root (used twice, for deviation and jitter) and a 64-step radix-2
// divider (used for deviation and mean, and for jitter unless the sum is
// zero), plus multiply-accumulate steps on the shared multiplier.
// A finished result waits in the output register while further items are
// accepted; a new report only waits if the previous one is still stalled.
// Configuration is written through cfg_write, cfg_index and cfg_data and
// must only change while no item is in progress.

`include "message_interval_jitter_monitor_core_assert.svh"

module message_interval_jitter_monitor_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [4:0]  record_terminal,
    input  logic [4:0]  record_subaddress,
    input  logic [31:0] timestamp_ms,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [19:0] record_count,
    output logic [31:0] min_interval_ms,
    output logic [31:0] max_interval_ms,
    output logic [39:0] mean_interval_q8,
    output logic [39:0] deviation_q8,
    output logic [23:0] jitter_percent_q8,
    output logic [2:0]  stability_class,
    output logic        is_stable,
    output logic        order_error
);
    import mijm_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // The controller owns the input handshake and sequences every step.
    mijm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .command  (command),
        .in_stall (in_stall),
        .cmd      (cmd),
        .stat     (stat)
    );

    // The datapath holds configuration, accumulators and the result item.
    mijm_datapath u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .record_terminal   (record_terminal),
        .record_subaddress (record_subaddress),
        .timestamp_ms      (timestamp_ms),
        .cmd               (cmd),
        .stat              (stat),
        .out_stall         (out_stall),
        .out_valid         (out_valid),
        .status            (status),
        .record_count      (record_count),
        .min_interval_ms   (min_interval_ms),
        .max_interval_ms   (max_interval_ms),
        .mean_interval_q8  (mean_interval_q8),
        .deviation_q8      (deviation_q8),
        .jitter_percent_q8 (jitter_percent_q8),
        .stability_class   (stability_class),
        .is_stable         (is_stable),
        .order_error       (order_error)
    );

    // A result is only loaded into a free output register, and is then shown.
    `MIJM_ASSERT_IMP(a_load_when_free, cmd.op == OP_LOAD, stat.out_free)
    `MIJM_ASSERT_NXT(a_load_shows_item, cmd.op == OP_LOAD, out_valid)
    // The square root and divider never signal done in the same cycle.
    `MIJM_ASSERT_IMP(a_units_exclusive, stat.sqrt_done, !stat.div_done)

endmodule
